### rtl/ffha_pkg.sv
// Package: status codes, register indexes, controller command and datapath status types.
`default_nettype none
package ffha_pkg;
  localparam int DATA_W    = 32;
  localparam int ST_W      = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 2'd1;

  localparam logic [DATA_W-1:0] HEAP_START_RST = 32'd204800;
  localparam logic [DATA_W-1:0] HEAP_END_RST   = 32'd4294967288;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [ST_W-1:0] ST_ALIGN    = 3'd2;
  localparam logic [ST_W-1:0] ST_OOM      = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTALLOC = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ISTEP,
    CMD_SSTEP,
    CMD_FLATCH,
    CMD_ACOMMIT,
    CMD_FCOMMIT,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t         op;
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_zero;
    logic size_odd;
    logic i_end;
    logic fit;
    logic slot_end;
    logic slot_free;
    logic slot_match;
    logic pos_stop;
    logic free_full;
  } dp_stat_t;
endpackage
`default_nettype wire

### rtl/ffha_req_if.sv
// Request channel interface: operation, size and release address.
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] request_size;
  logic [31:0] release_address;
  modport source (output valid, operation, request_size, release_address, input ready);
  modport sink   (input valid, operation, request_size, release_address, output ready);
endinterface
`default_nettype wire

### rtl/ffha_rsp_if.sv
// Result channel interface: block address, status and byte counts.
`default_nettype none
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [2:0]  status;
  logic [31:0] allocated_bytes;
  logic [31:0] peak_allocated_bytes;
  modport source (output valid, block_address, status, allocated_bytes,
                  peak_allocated_bytes, input ready);
  modport sink   (input valid, block_address, status, allocated_bytes,
                  peak_allocated_bytes, output ready);
endinterface
`default_nettype wire

### rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with coalescing of freed segments.
//  channel  | dir | payload
//  in_ch    | in  | operation, request_size, release_address
//  out_ch   | out | block_address, status, allocated_bytes, peak_allocated_bytes
//  cfg_*    | in  | heap_start (index 0), heap_end (index 1)
// One request at a time. The free and used tables are scanned one entry a cycle.
// Table insert/remove shifts happen in parallel at commit. Synchronous reset; no clearing pass.
// A result beat waiting on out_ch holds the next request at its emit, and with it
// acceptance of the one after.
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int FREE_SLOTS = 16,
  parameter int USED_SLOTS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ffha_req_if.sink                  in_ch,
  ffha_rsp_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata
);
  cmd_t     cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_dp #(.FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS)) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .stat                     (stat),
    .in_operation             (in_ch.operation),
    .in_size                  (in_ch.request_size),
    .in_addr                  (in_ch.release_address),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .out_block_address        (out_ch.block_address),
    .out_status               (out_ch.status),
    .out_allocated_bytes      (out_ch.allocated_bytes),
    .out_peak_allocated_bytes (out_ch.peak_allocated_bytes)
  );
endmodule
`default_nettype wire

### rtl/ffha_dp.sv
// Datapath: free and used segment tables, scan counters, byte counts, result registers.
`default_nettype none
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int FREE_SLOTS = 16,
  parameter int USED_SLOTS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output dp_stat_t                  stat,
  input  wire logic                 in_operation,
  input  wire logic [DATA_W-1:0]    in_size,
  input  wire logic [DATA_W-1:0]    in_addr,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  output logic [DATA_W-1:0]         out_block_address,
  output logic [ST_W-1:0]           out_status,
  output logic [DATA_W-1:0]         out_allocated_bytes,
  output logic [DATA_W-1:0]         out_peak_allocated_bytes
);
  localparam int FI = $clog2(FREE_SLOTS);
  localparam int FC = $clog2(FREE_SLOTS + 1);
  localparam int UI = $clog2(USED_SLOTS);
  localparam int UC = $clog2(USED_SLOTS + 1);

  logic [DATA_W-1:0] fs_r [FREE_SLOTS];
  logic [DATA_W-1:0] fe_r [FREE_SLOTS];
  logic [FC-1:0]     cnt_r;
  logic [DATA_W-1:0] us_r [USED_SLOTS];
  logic [DATA_W-1:0] ue_r [USED_SLOTS];
  logic [USED_SLOTS-1:0] vld_r;
  logic [DATA_W-1:0] cur_r, peak_r, hs_r, he_r;
  logic              op_r, prev_ok_r;
  logic [DATA_W-1:0] size_r, addr_r, bs_r, be_r, prev_e_r, res_addr_r;
  logic [FC-1:0]     idx_r;
  logic [UC-1:0]     slot_r;

  logic [FI-1:0]     ix, ixm1;
  logic [UI-1:0]     sx;
  logic [DATA_W-1:0] rd_s, rd_e, new_s, nc, hs_n, he_n;
  logic              jp, jn, cfg_hit;

  assign ix    = idx_r[FI-1:0];
  assign ixm1  = FI'(idx_r - FC'(1));
  assign sx    = slot_r[UI-1:0];
  assign rd_s  = fs_r[ix];
  assign rd_e  = fe_r[ix];
  assign new_s = rd_s + size_r;
  assign nc    = cur_r + size_r;
  assign jp    = prev_ok_r && (prev_e_r == bs_r);
  assign jn    = !stat.i_end && (rd_s == be_r);

  assign cfg_hit = cfg_we && (cfg_index == REG_HEAP_START || cfg_index == REG_HEAP_END);
  assign hs_n    = (cfg_index == REG_HEAP_START) ? cfg_wdata : hs_r;
  assign he_n    = (cfg_index == REG_HEAP_END) ? cfg_wdata : he_r;

  always_comb begin
    stat.op_free    = (op_r == OP_FREE);
    stat.size_zero  = (size_r == '0);
    stat.size_odd   = (size_r[2:0] != 3'd0);
    stat.i_end      = (idx_r >= cnt_r);
    stat.fit        = ((rd_e - rd_s) >= size_r);
    stat.slot_end   = (slot_r == UC'(USED_SLOTS));
    stat.slot_free  = !vld_r[sx];
    stat.slot_match = vld_r[sx] && (us_r[sx] == addr_r);
    stat.pos_stop   = stat.i_end || (rd_s > bs_r);
    stat.free_full  = !jp && !jn && (cnt_r == FC'(FREE_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= HEAP_START_RST;
      he_r   <= HEAP_END_RST;
      cnt_r  <= FC'(1);
      vld_r  <= '0;
      cur_r  <= '0;
      peak_r <= '0;
      for (int k = 0; k < FREE_SLOTS; k++) begin
        fs_r[k] <= (k == 0) ? HEAP_START_RST : '0;
        fe_r[k] <= (k == 0) ? HEAP_END_RST : '0;
      end
    end else if (cfg_hit) begin
      hs_r    <= hs_n;
      he_r    <= he_n;
      fs_r[0] <= hs_n;
      fe_r[0] <= he_n;
      cnt_r   <= (he_n > hs_n) ? FC'(1) : FC'(0);
      vld_r   <= '0;
      cur_r   <= '0;
    end else begin
      case (cmd.op)
        CMD_LOAD: begin
          op_r       <= in_operation;
          size_r     <= in_size;
          addr_r     <= in_addr;
          idx_r      <= '0;
          slot_r     <= '0;
          prev_ok_r  <= 1'b0;
          res_addr_r <= '0;
        end
        CMD_ISTEP: begin
          idx_r     <= idx_r + FC'(1);
          prev_ok_r <= 1'b1;
          prev_e_r  <= rd_e;
        end
        CMD_SSTEP: slot_r <= slot_r + UC'(1);
        CMD_FLATCH: begin
          bs_r <= us_r[sx];
          be_r <= ue_r[sx];
        end
        CMD_ACOMMIT: begin
          us_r[sx]   <= rd_s;
          ue_r[sx]   <= new_s;
          vld_r[sx]  <= 1'b1;
          res_addr_r <= rd_s;
          cur_r      <= nc;
          if (nc > peak_r) peak_r <= nc;
          if (new_s == rd_e) begin
            for (int k = 0; k < FREE_SLOTS - 1; k++) begin
              if (FC'(k) >= idx_r) begin
                fs_r[k] <= fs_r[k+1];
                fe_r[k] <= fe_r[k+1];
              end
            end
            cnt_r <= cnt_r - FC'(1);
          end else begin
            fs_r[ix] <= new_s;
          end
        end
        CMD_FCOMMIT: begin
          vld_r[sx] <= 1'b0;
          cur_r     <= cur_r - (be_r - bs_r);
          if (jp && jn) begin
            for (int k = 0; k < FREE_SLOTS - 1; k++) begin
              if (FC'(k) >= idx_r) begin
                fs_r[k] <= fs_r[k+1];
                fe_r[k] <= fe_r[k+1];
              end
            end
            fe_r[ixm1] <= rd_e;
            cnt_r      <= cnt_r - FC'(1);
          end else if (jp) begin
            fe_r[ixm1] <= be_r;
          end else if (jn) begin
            fs_r[ix] <= bs_r;
          end else begin
            for (int k = 1; k < FREE_SLOTS; k++) begin
              if (FC'(k) > idx_r && FC'(k) <= cnt_r) begin
                fs_r[k] <= fs_r[k-1];
                fe_r[k] <= fe_r[k-1];
              end
            end
            fs_r[ix] <= bs_r;
            fe_r[ix] <= be_r;
            cnt_r    <= cnt_r + FC'(1);
          end
        end
        CMD_EMIT: begin
          out_block_address        <= (cmd.st == ST_OK) ? res_addr_r : '0;
          out_status               <= cmd.st;
          out_allocated_bytes      <= cur_r;
          out_peak_allocated_bytes <= peak_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/ffha_ctrl.sv
// Controller: request sequencing, scan control and channel handshakes.
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output cmd_t          cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_A_SCAN, S_A_SLOT, S_F_FIND, S_F_POS, S_F_COMMIT, S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [ST_W-1:0] st_r, st_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NONE;
    cmd.st        = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op_free) state_nxt = S_F_FIND;
        else if (stat.size_zero) begin
          st_nxt    = ST_ZERO;
          state_nxt = S_FIN;
        end else if (stat.size_odd) begin
          st_nxt    = ST_ALIGN;
          state_nxt = S_FIN;
        end else state_nxt = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (stat.i_end) begin
          st_nxt    = ST_OOM;
          state_nxt = S_FIN;
        end else if (stat.fit) state_nxt = S_A_SLOT;
        else cmd.op = CMD_ISTEP;
      end
      S_A_SLOT: begin
        if (stat.slot_end) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FIN;
        end else if (stat.slot_free) begin
          cmd.op    = CMD_ACOMMIT;
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end else cmd.op = CMD_SSTEP;
      end
      S_F_FIND: begin
        if (stat.slot_end) begin
          st_nxt    = ST_NOTALLOC;
          state_nxt = S_FIN;
        end else if (stat.slot_match) begin
          cmd.op    = CMD_FLATCH;
          state_nxt = S_F_POS;
        end else cmd.op = CMD_SSTEP;
      end
      S_F_POS: begin
        if (stat.pos_stop) state_nxt = S_F_COMMIT;
        else cmd.op = CMD_ISTEP;
      end
      S_F_COMMIT: begin
        if (stat.free_full) st_nxt = ST_FULL;
        else begin
          cmd.op = CMD_FCOMMIT;
          st_nxt = ST_OK;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = CMD_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

### verif/ffha_checker.sv
// Checker: watches request and result beats, predicts each result and compares.
`timescale 1ns / 100ps
module ffha_checker
  import ffha_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    req_valid,
  input  wire logic    req_ready,
  input  wire logic    req_op,
  input  wire logic [31:0] req_size,
  input  wire logic [31:0] req_addr,
  input  wire logic    rsp_valid,
  input  wire logic    rsp_ready,
  input  wire logic [31:0] rsp_addr,
  input  wire logic [2:0]  rsp_status,
  input  wire logic [31:0] rsp_alloc,
  input  wire logic [31:0] rsp_peak,
  input  wire logic    cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  output int           fail_count,
  output int           pending
);
  localparam int NFREE = 16;
  localparam int NUSED = 32;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
    logic [31:0] alloc;
    logic [31:0] peak;
  } heap_rsp_t;

  heap_rsp_t rsp_q[$];

  logic [31:0] hs, he;
  logic [31:0] fs[NFREE], fe[NFREE];
  int          fcnt;
  logic [31:0] us[NUSED], ue[NUSED];
  logic        uv[NUSED];
  logic [31:0] cur, peak;

  task automatic rebuild_heap();
    fcnt = 0;
    for (int k = 0; k < NUSED; k++) uv[k] = 1'b0;
    if (he > hs) begin
      fs[0] = hs;
      fe[0] = he;
      fcnt = 1;
    end
    cur = '0;
  endtask

  task automatic drop_free(int idx);
    for (int k = idx; k + 1 < fcnt; k++) begin
      fs[k] = fs[k+1];
      fe[k] = fe[k+1];
    end
    if (fcnt > 0) fcnt--;
  endtask

  task automatic predict_heap(logic op, logic [31:0] size, logic [31:0] ra,
                              output heap_rsp_t r);
    int i, slot;
    logic [31:0] a, bs, be;
    logic [2:0] st;
    logic jp, jn;
    a = '0;
    st = ST_OK;
    if (op == OP_ALLOC) begin
      if (size == 0) st = ST_ZERO;
      else if (size[2:0] != 0) st = ST_ALIGN;
      else begin
        for (i = 0; i < fcnt; i++) if (fe[i] - fs[i] >= size) break;
        if (i >= fcnt) st = ST_OOM;
        else begin
          for (slot = 0; slot < NUSED; slot++) if (!uv[slot]) break;
          if (slot >= NUSED) st = ST_FULL;
          else begin
            a = fs[i];
            us[slot] = fs[i];
            ue[slot] = fs[i] + size;
            uv[slot] = 1'b1;
            fs[i] = ue[slot];
            if (fs[i] == fe[i]) drop_free(i);
            cur = cur + size;
            if (cur > peak) peak = cur;
          end
        end
      end
    end else begin
      for (slot = 0; slot < NUSED; slot++) if (uv[slot] && us[slot] == ra) break;
      if (slot >= NUSED) st = ST_NOTALLOC;
      else begin
        bs = us[slot];
        be = ue[slot];
        for (i = 0; i < fcnt; i++) if (fs[i] > bs) break;
        jp = i > 0 && fe[i-1] == bs;
        jn = i < fcnt && fs[i] == be;
        if (jp && jn) begin
          fe[i-1] = fe[i];
          drop_free(i);
        end else if (jp) fe[i-1] = be;
        else if (jn) fs[i] = bs;
        else if (fcnt >= NFREE) st = ST_FULL;
        else begin
          for (int k = fcnt; k > i; k--) begin
            fs[k] = fs[k-1];
            fe[k] = fe[k-1];
          end
          fs[i] = bs;
          fe[i] = be;
          fcnt++;
        end
        if (st == ST_OK) begin
          uv[slot] = 1'b0;
          cur = cur - (be - bs);
        end
      end
    end
    r = '{addr: a, status: st, alloc: cur, peak: peak};
  endtask

  always @(posedge clk) begin
    heap_rsp_t r, e;
    if (!rst_n) begin
      hs = HEAP_START_RST;
      he = HEAP_END_RST;
      peak = '0;
      rebuild_heap();
      rsp_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we && (cfg_index == REG_HEAP_START || cfg_index == REG_HEAP_END)) begin
        if (cfg_index == REG_HEAP_START) hs = cfg_wdata;
        else he = cfg_wdata;
        rebuild_heap();
      end
      if (req_valid && req_ready) begin
        predict_heap(req_op, req_size, req_addr, r);
        rsp_q.push_back(r);
      end
      if (rsp_valid && rsp_ready) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected result beat");
          fail_count <= fail_count + 1;
        end else begin
          e = rsp_q.pop_front();
          if (rsp_addr !== e.addr || rsp_status !== e.status ||
              rsp_alloc !== e.alloc || rsp_peak !== e.peak) begin
            if (rsp_addr !== e.addr)
              $error("block_address exp %h got %h", e.addr, rsp_addr);
            if (rsp_status !== e.status)
              $error("status exp %0d got %0d", e.status, rsp_status);
            if (rsp_alloc !== e.alloc)
              $error("allocated_bytes exp %0d got %0d", e.alloc, rsp_alloc);
            if (rsp_peak !== e.peak)
              $error("peak_allocated_bytes exp %0d got %0d", e.peak, rsp_peak);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= rsp_q.size();
    end
  end
endmodule

### verif/tb_first_fit_heap_allocator.sv
// Testbench top: clock, reset, request and register stimulus, final verdict.
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  int fail_count, pending;
  longint cycles;
  logic [31:0] live_addr[$];

  ffha_req_if in_ch();
  ffha_rsp_if out_ch();

  first_fit_heap_allocator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ffha_checker chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req_op(in_ch.operation),
    .req_size(in_ch.request_size), .req_addr(in_ch.release_address),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready),
    .rsp_addr(out_ch.block_address), .rsp_status(out_ch.status),
    .rsp_alloc(out_ch.allocated_bytes), .rsp_peak(out_ch.peak_allocated_bytes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("tb_first_fit_heap_allocator: done, errors");
        $finish;
      end
    end
  end

  // learn block addresses from result beats, for realistic frees
  always @(posedge clk)
    if (out_ch.valid && out_ch.ready && out_ch.status == ST_OK &&
        out_ch.block_address != 0)
      live_addr.push_back(out_ch.block_address);

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_req(logic op, logic [31:0] size, logic [31:0] ra);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.request_size <= size;
    in_ch.release_address <= ra;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    live_addr.delete();
  endtask

  task automatic pick_free_addr(output logic [31:0] a);
    int k;
    a = $urandom;
    if (live_addr.size() != 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      a = live_addr[k];
      live_addr.delete(k);
    end
  endtask

  task automatic random_phase(int n, logic [31:0] span);
    logic [31:0] a, s;
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 9))
        0: send_req(OP_ALLOC, $urandom, $urandom);
        1: send_req(OP_ALLOC, $urandom_range(1, 64), $urandom);
        2, 3, 4, 5: begin
          s = $urandom_range(1, span) << 3;
          send_req(OP_ALLOC, s, $urandom);
        end
        default: begin
          pick_free_addr(a);
          send_req(OP_FREE, $urandom, a);
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_HEAP_START;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.request_size = '0;
    in_ch.release_address = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(OP_ALLOC, 32'd0, 32'd0);
    send_req(OP_ALLOC, 32'd7, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_req(OP_ALLOC, 32'hFFFF_FFF8, 32'd0);
    send_req(OP_ALLOC, 32'd8, 32'd0);
    send_req(OP_ALLOC, 32'h0001_0000, 32'd0);
    send_req(OP_ALLOC, 32'd64, 32'd0);
    send_req(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    send_req(OP_FREE, 32'd0, 32'd204808);
    send_req(OP_FREE, 32'd0, 32'd204800);
    send_req(OP_FREE, 32'd0, 32'd204808);
    send_req(OP_ALLOC, 32'hF000_0000, 32'd0);
    send_req(OP_ALLOC, 32'hF000_0000, 32'd0);

    write_reg(REG_HEAP_START, 32'd4096);
    write_reg(REG_HEAP_END, 32'd4096 + 32'd512);
    // fill the used table, then overflow it
    for (int j = 0; j < 33; j++) send_req(OP_ALLOC, 32'd8, 32'd0);
    // free every other block to fill the free table
    for (int j = 0; j < 34; j += 2) send_req(OP_FREE, 32'd0, 32'd4096 + j * 8);
    send_req(OP_FREE, 32'd0, 32'd4096 + 8);
    live_addr.delete();
    random_phase(150, 8);

    write_reg(2'd2, 32'hDEAD_BEEF);
    write_reg(REG_HEAP_END, 32'd100);
    send_req(OP_ALLOC, 32'd8, 32'd0);
    write_reg(REG_HEAP_START, 32'd0);
    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
    random_phase(400, 32'h0FFF_FFFF);

    write_reg(REG_HEAP_START, 32'hFFFF_F000);
    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
    random_phase(400, 64);

    write_reg(REG_HEAP_START, 32'h1000);
    write_reg(REG_HEAP_END, 32'h1400);
    random_phase(650, 16);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("tb_first_fit_heap_allocator: done, clean");
    else
      $display("tb_first_fit_heap_allocator: done, errors");
    $finish;
  end
endmodule
